### rtl/core/tfdq_pkg.sv
`timescale 1ns / 1ps
// Package for the train fault debounce qualifier.
// Holds the beat layouts, register indexes, reset values and fault bit positions.
// No dependencies.
package tfdq_pkg;

    // Fault condition count and bit positions in every 6-bit mask
    localparam int NUM_COND   = 6;
    localparam int COND_SPEED = 0;
    localparam int COND_BRAKE = 1;
    localparam int COND_SOS   = 2;
    localparam int COND_SPAD  = 3;
    localparam int COND_RADIO = 4;
    localparam int COND_RFID  = 5;

    // Default consecutive-fail counter width
    localparam int COUNTER_WIDTH_DEF = 8;

    // Input field codes
    localparam logic [7:0] SOS_PRESSED   = 8'd1;
    localparam logic [7:0] ASPECT_DANGER = 8'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd3;

    localparam logic [7:0]  CONFIRM_COUNT_RST = 8'd4;
    localparam logic [15:0] BRAKE_LIMIT_RST   = 16'd20;
    localparam logic [31:0] RADIO_TIMEOUT_RST = 32'd5000;
    localparam logic [15:0] TICK_PERIOD_RST   = 16'd500;

    // Input tdata layout, lowest bit first
    localparam int IN_DATA_W   = 80;
    localparam int IN_USER_W   = 1;
    localparam int IN_SPD_LO   = 0;
    localparam int IN_PERM_LO  = 8;
    localparam int IN_BP_LO    = 16;
    localparam int IN_SOS_LO   = 32;
    localparam int IN_ASP_LO   = 40;
    localparam int IN_BARS_LO  = 48;
    localparam int IN_TAG_LO   = 56;
    localparam int IN_RSTAT_LO = 72;

    // Output tdata layout, lowest bit first, zero padded to 56 bits
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_FAIL_LO = 0;
    localparam int OUT_CONF_LO = 6;
    localparam int OUT_NEW_LO  = 12;
    localparam int OUT_GAP_LO  = 18;
    localparam int OUT_USED_W  = 50;

endpackage

### rtl/core/train_fault_debounce_qualifier_top.sv
`timescale 1ns / 1ps
// Train fault debounce qualifier, top level.
// Depends on tfdq_pkg.
//
// One input beat is one sensor tick and yields exactly one output beat. A beat
// is registered on entry, then checked against six fault conditions (overspeed,
// low brake pipe, SOS, danger aspect while moving, radio silence, tag/RFID
// fault) and the result registered: a beat passes the input register and then
// the result register, and can be held in either while the sink stalls. A
// new beat can be taken every cycle while the sink accepts; throughput is one
// beat per clock unless the sink stalls; the per-condition fail counters, the
// fault latch and the radio gap register update once per beat. The output register
// holds a result while the sink stalls and the input stage keeps taking beats
// until both stages are full. Every beat advances time by tick_period_ms; a
// beat with sample_valid low only updates the radio gap. Each condition keeps
// a consecutive-fail counter that clears on a pass and saturates at the
// effective threshold min(max(confirm_count,1), 2^COUNTER_WIDTH-1); reaching
// the threshold latches the fault until reset. Configuration writes take
// effect at once and are meant to be made while no beat is in flight.
module train_fault_debounce_qualifier_top #(
    parameter int COUNTER_WIDTH = tfdq_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [tfdq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfdq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Sample stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // speed_actual[7:0], speed_permitted[15:8], brake_pipe[31:16], sos_state[39:32],
    // signal_aspect[47:40], rf_signal_bars[55:48], tag_id[71:56], rfid_status[79:72]
    input  logic [tfdq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // sample_valid[0]
    input  logic [tfdq_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    // Result stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // failing_now[5:0], confirmed_mask[11:6], newly_confirmed[17:12],
    // radio_gap_ms[49:18], zero [55:50]
    output logic [tfdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int NC = tfdq_pkg::NUM_COND;
    // Widest value the threshold logic has to compare against
    localparam logic [16:0] CNT_MAX = 17'((17'd1 << COUNTER_WIDTH) - 17'd1);

    // Configuration registers
    logic [7:0]  r_confirm_count;
    logic [15:0] r_brake_limit;
    logic [31:0] r_radio_timeout;
    logic [15:0] r_tick_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_count <= tfdq_pkg::CONFIRM_COUNT_RST;
            r_brake_limit   <= tfdq_pkg::BRAKE_LIMIT_RST;
            r_radio_timeout <= tfdq_pkg::RADIO_TIMEOUT_RST;
            r_tick_period   <= tfdq_pkg::TICK_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tfdq_pkg::CFG_CONFIRM_COUNT: r_confirm_count <= i_cfg_wdata[7:0];
                tfdq_pkg::CFG_BRAKE_LIMIT:   r_brake_limit   <= i_cfg_wdata[15:0];
                tfdq_pkg::CFG_RADIO_TIMEOUT: r_radio_timeout <= i_cfg_wdata[31:0];
                tfdq_pkg::CFG_TICK_PERIOD:   r_tick_period   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: stage 1 = input register, stage 2 = result register
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load_ok;
    logic s1_fire;

    assign out_load_ok     = !r_out_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && out_load_ok;
    assign o_s_axis_tready = !r_s1_valid || out_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_s1_valid <= i_s_axis_tvalid;
            if (out_load_ok)     r_out_valid <= r_s1_valid;
        end
    end

    // Input register (payload, no reset)
    logic [tfdq_pkg::IN_DATA_W-1:0] r_s1_data;
    logic                           r_s1_sample_ok;

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_s1_data      <= i_s_axis_tdata;
            r_s1_sample_ok <= i_s_axis_tuser[0];
        end
    end

    // Field decode
    logic [7:0]  spd, perm, sos, aspect, bars, rstat;
    logic [15:0] bp, tag;

    assign spd    = r_s1_data[tfdq_pkg::IN_SPD_LO   +: 8];
    assign perm   = r_s1_data[tfdq_pkg::IN_PERM_LO  +: 8];
    assign bp     = r_s1_data[tfdq_pkg::IN_BP_LO    +: 16];
    assign sos    = r_s1_data[tfdq_pkg::IN_SOS_LO   +: 8];
    assign aspect = r_s1_data[tfdq_pkg::IN_ASP_LO   +: 8];
    assign bars   = r_s1_data[tfdq_pkg::IN_BARS_LO  +: 8];
    assign tag    = r_s1_data[tfdq_pkg::IN_TAG_LO   +: 16];
    assign rstat  = r_s1_data[tfdq_pkg::IN_RSTAT_LO +: 8];

    // Radio gap kept directly instead of time and last-reception stamps:
    // gap advances by the tick and drops to zero on any valid reception.
    logic [31:0] r_gap;
    logic [31:0] n_gap;

    always_comb begin
        if (r_s1_sample_ok && (bars != 8'd0)) n_gap = 32'd0;
        else                                   n_gap = r_gap + {16'd0, r_tick_period};
    end

    // Effective threshold
    logic [16:0]              thr_raw;
    logic [COUNTER_WIDTH-1:0] thr;

    always_comb begin
        thr_raw = (r_confirm_count == 8'd0) ? 17'd1 : {9'd0, r_confirm_count};
        if (thr_raw > CNT_MAX) thr = CNT_MAX[COUNTER_WIDTH-1:0];
        else                   thr = thr_raw[COUNTER_WIDTH-1:0];
    end

    // Condition checks
    logic [NC-1:0] failing;

    always_comb begin
        failing = '0;
        if (r_s1_sample_ok) begin
            failing[tfdq_pkg::COND_SPEED] = (spd != 8'd0) && (perm != 8'd0) && (spd > perm);
            failing[tfdq_pkg::COND_BRAKE] = (bp != 16'd0) && (bp < r_brake_limit);
            failing[tfdq_pkg::COND_SOS]   = (sos == tfdq_pkg::SOS_PRESSED);
            failing[tfdq_pkg::COND_SPAD]  = (aspect == tfdq_pkg::ASPECT_DANGER) &&
                                            (spd != 8'd0);
            failing[tfdq_pkg::COND_RADIO] = (n_gap > r_radio_timeout);
            failing[tfdq_pkg::COND_RFID]  = (tag == 16'd0) || (rstat != 8'd0);
        end
    end

    // Per-condition fail counters and the confirmed latch
    logic [COUNTER_WIDTH-1:0] r_cnt [NC];
    logic [COUNTER_WIDTH-1:0] n_cnt [NC];
    logic [NC-1:0]            r_latch;
    logic [NC-1:0]            n_latch;
    logic [NC-1:0]            fresh;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (!r_s1_sample_ok)  n_cnt[i] = r_cnt[i];
            else if (failing[i])  n_cnt[i] = (r_cnt[i] < thr) ? r_cnt[i] + 1'b1 : r_cnt[i];
            else                  n_cnt[i] = '0;
            fresh[i] = r_s1_sample_ok && (n_cnt[i] >= thr) && !r_latch[i];
        end
        n_latch = r_latch | fresh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= '0;
            r_latch <= '0;
            for (int i = 0; i < NC; i++) r_cnt[i] <= '0;
        end else if (s1_fire) begin
            r_gap   <= n_gap;
            r_latch <= n_latch;
            for (int i = 0; i < NC; i++) r_cnt[i] <= n_cnt[i];
        end
    end

    // Result register (payload, no reset)
    logic [tfdq_pkg::OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= {{(tfdq_pkg::OUT_DATA_W - tfdq_pkg::OUT_USED_W){1'b0}},
                           n_gap, fresh, n_latch, failing};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### rtl/core/tfdq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the train fault debounce qualifier, bound to the top.
// Depends on tfdq_pkg.
module tfdq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [tfdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [5:0] fail_w, conf_w, new_w;

    assign fail_w = o_m_axis_tdata[tfdq_pkg::OUT_FAIL_LO +: 6];
    assign conf_w = o_m_axis_tdata[tfdq_pkg::OUT_CONF_LO +: 6];
    assign new_w  = o_m_axis_tdata[tfdq_pkg::OUT_NEW_LO  +: 6];

    // A fault confirmed by this beat is in the latched mask
    a_new_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((new_w & ~conf_w) == 6'd0))
        else $error("newly confirmed fault missing from confirmed mask");

    // A fault can only be confirmed by a beat on which it fails
    a_new_failing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((new_w & ~fail_w) == 6'd0))
        else $error("fault confirmed on a passing beat");

    // Nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

endmodule

bind train_fault_debounce_qualifier_top tfdq_checker u_tfdq_checker (.*);

### bench/train_fault_debounce_qualifier_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the train fault debounce qualifier: drives sensor ticks,
// predicts each result beat with a local debounce model and compares field by field.
// Depends on tfdq_pkg and train_fault_debounce_qualifier_top.
module train_fault_debounce_qualifier_top_tb;
    import tfdq_pkg::*;

    // Saturation point of the per-condition fail runs, DUT built with the default width
    localparam int unsigned RUN_MAX = (1 << COUNTER_WIDTH_DEF) - 1;
    // Cycles with no beat on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    typedef struct {
        logic        ok;
        logic [7:0]  speed;
        logic [7:0]  permitted;
        logic [15:0] brake_pipe;
        logic [7:0]  sos;
        logic [7:0]  aspect;
        logic [7:0]  bars;
        logic [15:0] tag;
        logic [7:0]  rfid_stat;
    } tick_sample_t;

    typedef struct {
        logic [NUM_COND-1:0] failing;
        logic [NUM_COND-1:0] latched;
        logic [NUM_COND-1:0] fresh;
        logic [31:0]         gap;
    } tick_verdict_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    train_fault_debounce_qualifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow of the qualifier: registers and debounce state
    logic [7:0]  m_confirm;
    logic [15:0] m_brake_limit;
    logic [31:0] m_radio_timeout;
    logic [15:0] m_tick;
    int unsigned m_fail_run [NUM_COND];
    logic [NUM_COND-1:0] m_latch;
    logic [31:0] m_clock;
    logic [31:0] m_last_rx;

    tick_verdict_t verdict_q [$];
    int mismatch_count    = 0;
    int hang_cycles       = 0;
    int sink_hold_cycles  = 0;
    bit no_idle           = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // One tick of the debounce qualifier; advances the shadow state
    function automatic tick_verdict_t qualify_tick(input tick_sample_t s);
        tick_verdict_t v;
        int unsigned   thr;
        v.failing = '0;
        v.fresh   = '0;
        m_clock   = m_clock + {16'd0, m_tick};
        if (s.ok) begin
            thr = (m_confirm == 8'd0) ? 1 : 32'(m_confirm);
            if (thr > RUN_MAX) thr = RUN_MAX;
            if (s.bars != 8'd0) m_last_rx = m_clock;
            v.gap = m_clock - m_last_rx;
            v.failing[COND_SPEED] = s.speed != 0 && s.permitted != 0 && s.speed > s.permitted;
            v.failing[COND_BRAKE] = s.brake_pipe != 0 && s.brake_pipe < m_brake_limit;
            v.failing[COND_SOS]   = s.sos == SOS_PRESSED;
            v.failing[COND_SPAD]  = s.aspect == ASPECT_DANGER && s.speed != 0;
            v.failing[COND_RADIO] = v.gap > m_radio_timeout;
            v.failing[COND_RFID]  = s.tag == 0 || s.rfid_stat != 0;
            for (int c = 0; c < NUM_COND; c++) begin
                if (v.failing[c]) begin
                    if (m_fail_run[c] < thr) m_fail_run[c]++;
                end else begin
                    m_fail_run[c] = 0;
                end
                if (m_fail_run[c] >= thr && !m_latch[c]) begin
                    m_latch[c] = 1'b1;
                    v.fresh[c] = 1'b1;
                end
            end
        end else begin
            v.gap = m_clock - m_last_rx;
        end
        v.latched = m_latch;
        return v;
    endfunction

    // A tick that passes every check
    function automatic tick_sample_t clean_sample();
        tick_sample_t s;
        s.ok = 1'b1;
        s.speed = 8'd50;
        s.permitted = 8'd80;
        s.brake_pipe = 16'd50;
        s.sos = 8'd0;
        s.aspect = 8'd0;
        s.bars = 8'd3;
        s.tag = 16'h1234;
        s.rfid_stat = 8'd0;
        return s;
    endfunction

    // Every field random over its full range
    function automatic tick_sample_t noise_sample();
        tick_sample_t s;
        s.ok = 1'($urandom);
        s.speed = 8'($urandom);
        s.permitted = 8'($urandom);
        s.brake_pipe = 16'($urandom);
        s.sos = 8'($urandom);
        s.aspect = 8'($urandom);
        s.bars = 8'($urandom);
        s.tag = 16'($urandom);
        s.rfid_stat = 8'($urandom);
        return s;
    endfunction

    // Conditions in push mostly fail, the rest mostly pass
    function automatic tick_sample_t random_sample(input logic [NUM_COND-1:0] push);
        tick_sample_t        s;
        logic [NUM_COND-1:0] fail;
        for (int c = 0; c < NUM_COND; c++)
            fail[c] = push[c] ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 5) == 0);
        s.ok = $urandom_range(0, 11) != 0;

        if (fail[COND_SPEED]) begin
            s.permitted = 8'($urandom_range(1, 254));
            s.speed = 8'($urandom_range(int'(s.permitted) + 1, 255));
        end else begin
            case ($urandom_range(0, 3))
                0: begin s.speed = 8'd0; s.permitted = 8'($urandom); end
                1: begin s.permitted = 8'd0; s.speed = 8'($urandom); end
                default: begin
                    s.permitted = 8'($urandom);
                    s.speed = 8'($urandom_range(0, int'(s.permitted)));
                end
            endcase
        end

        if (fail[COND_BRAKE] && m_brake_limit > 16'd1)
            s.brake_pipe = 16'($urandom_range(1, int'(m_brake_limit) - 1));
        else if (fail[COND_BRAKE] || $urandom_range(0, 4) == 0)
            s.brake_pipe = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        else
            s.brake_pipe = 16'($urandom_range(int'(m_brake_limit), 65535));

        if (fail[COND_SOS])
            s.sos = SOS_PRESSED;
        else
            s.sos = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(2, 255));

        if (fail[COND_SPAD]) begin
            s.aspect = ASPECT_DANGER;
            if (s.speed == 8'd0) s.speed = 8'($urandom_range(1, 255));
        end else if (s.speed == 8'd0 && $urandom_range(0, 1) == 0) begin
            s.aspect = ASPECT_DANGER;   // danger aspect while standing still
        end else begin
            s.aspect = 8'($urandom);
            if (s.aspect == ASPECT_DANGER) s.aspect = 8'd0;
        end

        s.bars = fail[COND_RADIO] ? 8'd0 : 8'($urandom_range(1, 255));

        if (fail[COND_RFID]) begin
            if ($urandom_range(0, 1) == 0) begin
                s.tag = 16'd0;
                s.rfid_stat = 8'($urandom);
            end else begin
                s.tag = 16'($urandom);
                s.rfid_stat = 8'($urandom_range(1, 255));
            end
        end else begin
            s.tag = 16'($urandom_range(1, 65535));
            s.rfid_stat = 8'd0;
        end
        return s;
    endfunction

    // Pause length: mostly short, a few long
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int gap_len();
        if (no_idle || $urandom_range(0, 1) == 0) return 0;
        return pause_len();
    endfunction

    task automatic sender_idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
    endtask

    // Offer one tick, record its expected result on acceptance, then maybe idle
    task automatic send_sample(input tick_sample_t s);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = '0;
        i_s_axis_tdata[IN_SPD_LO   +: 8]  = s.speed;
        i_s_axis_tdata[IN_PERM_LO  +: 8]  = s.permitted;
        i_s_axis_tdata[IN_BP_LO    +: 16] = s.brake_pipe;
        i_s_axis_tdata[IN_SOS_LO   +: 8]  = s.sos;
        i_s_axis_tdata[IN_ASP_LO   +: 8]  = s.aspect;
        i_s_axis_tdata[IN_BARS_LO  +: 8]  = s.bars;
        i_s_axis_tdata[IN_TAG_LO   +: 16] = s.tag;
        i_s_axis_tdata[IN_RSTAT_LO +: 8]  = s.rfid_stat;
        i_s_axis_tuser = s.ok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        verdict_q.push_back(qualify_tick(s));
        sender_idle(gap_len());
    endtask

    // Drop tvalid and wait until every expected beat has come out
    task automatic wait_results_done();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the pipeline empty
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(posedge i_clk);
        case (idx)
            CFG_CONFIRM_COUNT: m_confirm = value[7:0];
            CFG_BRAKE_LIMIT:   m_brake_limit = value[15:0];
            CFG_RADIO_TIMEOUT: m_radio_timeout = value;
            CFG_TICK_PERIOD:   m_tick = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] confirm, input logic [15:0] brake,
                              input logic [31:0] timeout, input logic [15:0] tick);
        cfg_write(CFG_CONFIRM_COUNT, {24'd0, confirm});
        cfg_write(CFG_BRAKE_LIMIT, {16'd0, brake});
        cfg_write(CFG_RADIO_TIMEOUT, timeout);
        cfg_write(CFG_TICK_PERIOD, {16'd0, tick});
    endtask

    // Bursts that keep a chosen set of conditions (possibly none) failing, with some pure noise
    task automatic run_random(input int n_items, input int max_burst);
        int                  sent;
        int                  burst;
        logic [NUM_COND-1:0] push;
        tick_sample_t        s;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, max_burst);
            case ($urandom_range(0, 3))
                0, 1: push = NUM_COND'(1 << $urandom_range(0, NUM_COND - 1));
                2:    push = NUM_COND'($urandom);
                default: push = '0;
            endcase
            repeat (burst) begin
                s = ($urandom_range(0, 9) == 0) ? noise_sample() : random_sample(push);
                send_sample(s);
                sent++;
            end
        end
    endtask

    // Reset register values and each condition at its edges
    task automatic test_reset_values();
        tick_sample_t s;
        s = clean_sample(); send_sample(s);
        s = clean_sample(); s.speed = 8'hFF; s.permitted = 8'hFE; send_sample(s);
        s = clean_sample(); s.speed = 8'hFF; s.permitted = 8'h00; send_sample(s);
        s = clean_sample(); s.speed = 8'hFF; s.permitted = 8'hFF; send_sample(s);
        s = clean_sample(); s.speed = 8'h00; s.permitted = 8'h00; send_sample(s);
        s = clean_sample(); s.brake_pipe = 16'd19; send_sample(s);
        s = clean_sample(); s.brake_pipe = 16'd20; send_sample(s);
        s = clean_sample(); s.brake_pipe = 16'd0; send_sample(s);
        s = clean_sample(); s.sos = SOS_PRESSED; send_sample(s);
        s = clean_sample(); s.sos = 8'hFF; send_sample(s);
        s = clean_sample(); s.aspect = ASPECT_DANGER; s.speed = 8'd0; send_sample(s);
        s = clean_sample(); s.aspect = ASPECT_DANGER; s.speed = 8'd1; send_sample(s);
        s = clean_sample(); s.tag = 16'd0; send_sample(s);
        s = clean_sample(); s.tag = 16'hFFFF; s.rfid_stat = 8'hFF; send_sample(s);
        // invalid read: every check but the radio one would fail, only time may move
        s.ok = 1'b0; s.speed = 8'hFF; s.permitted = 8'd1; s.brake_pipe = 16'd1;
        s.sos = SOS_PRESSED; s.aspect = ASPECT_DANGER; s.bars = 8'd0; s.tag = 16'd0;
        send_sample(s);
        // radio silence: past 5000 ms after ten ticks, confirmed on the fourth failing tick
        repeat (14) begin
            s = clean_sample(); s.bars = 8'd0; send_sample(s);
        end
    endtask

    // Saturation at the widest threshold, and a zero count acting as one
    task automatic test_confirm_threshold();
        tick_sample_t s;
        cfg_write(CFG_CONFIRM_COUNT, 32'd255);
        repeat (257) begin
            s = clean_sample(); s.speed = 8'd200; s.permitted = 8'd100; send_sample(s);
        end
        s = clean_sample(); send_sample(s);
        cfg_write(CFG_CONFIRM_COUNT, 32'd0);
        s = clean_sample(); s.sos = SOS_PRESSED; send_sample(s);
        cfg_write(CFG_CONFIRM_COUNT, 32'd1);
        s = clean_sample(); s.brake_pipe = 16'd1; send_sample(s);
        s = clean_sample(); send_sample(s);
    endtask

    // Frozen time, zero timeout, and the widest tick with the widest timeout
    task automatic test_time_base();
        tick_sample_t s;
        cfg_write(CFG_CONFIRM_COUNT, 32'd40);
        cfg_write(CFG_TICK_PERIOD, 32'd0);
        cfg_write(CFG_RADIO_TIMEOUT, 32'd0);
        repeat (3) begin
            s = clean_sample(); s.bars = 8'd0; send_sample(s);
        end
        cfg_write(CFG_TICK_PERIOD, 32'd1);
        repeat (3) begin
            s = clean_sample(); s.bars = 8'd0; send_sample(s);
        end
        cfg_write(CFG_RADIO_TIMEOUT, 32'hFFFF_FFFF);
        cfg_write(CFG_TICK_PERIOD, 32'd65535);
        no_idle = 1'b1;
        // large steps, radio reception present, then mostly lost
        for (int i = 0; i < 32; i++) begin
            s = random_sample(((i / 16) % 2 != 0) ? NUM_COND'(1 << COND_RADIO) : '0);
            send_sample(s);
        end
        no_idle = 1'b0;
    endtask

    // Long sink hold while ticks keep coming, then a full drain mid-stream
    task automatic test_backpressure();
        set_config(8'd30, 16'd300, 32'd3000, 16'd250);
        run_random(60, 40);
        sink_hold_cycles = 200;
        run_random(60, 40);
        wait_results_done();
        run_random(40, 40);
    endtask

    task automatic test_random_phases();
        set_config(8'd8, 16'hFFFF, 32'd0, 16'd1);
        no_idle = 1'b1;
        run_random(100, 12);
        no_idle = 1'b0;
        run_random(200, 12);
        set_config(8'd3, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
        run_random(200, 6);
        repeat (2) begin
            set_config(8'($urandom_range(2, 20)), 16'($urandom),
                       32'($urandom_range(0, 20000)), 16'($urandom_range(1, 2000)));
            run_random(150, 25);
        end
    endtask

    // Sink side: random stalls, plus the forced hold-off
    initial begin : sink_stall
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready = 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 30) begin
                i_m_axis_tready = 1'b0;
                stall_left = pause_len() - 1;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        tick_verdict_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t ns: result beat 0x%0h with no tick pending, expected none",
                             $time, o_m_axis_tdata);
            end else begin
                want = verdict_q.pop_front();
                check_field("failing_now", 32'(want.failing),
                            32'(o_m_axis_tdata[OUT_FAIL_LO +: NUM_COND]));
                check_field("confirmed_mask", 32'(want.latched),
                            32'(o_m_axis_tdata[OUT_CONF_LO +: NUM_COND]));
                check_field("newly_confirmed", 32'(want.fresh),
                            32'(o_m_axis_tdata[OUT_NEW_LO +: NUM_COND]));
                check_field("radio_gap_ms", want.gap, o_m_axis_tdata[OUT_GAP_LO +: 32]);
                check_field("padding", '0, 32'(o_m_axis_tdata[OUT_DATA_W-1:OUT_USED_W]));
            end
        end
    end

    // Hang detector: no beat on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        m_confirm = CONFIRM_COUNT_RST;
        m_brake_limit = BRAKE_LIMIT_RST;
        m_radio_timeout = RADIO_TIMEOUT_RST;
        m_tick = TICK_PERIOD_RST;
        foreach (m_fail_run[c]) m_fail_run[c] = 0;
        m_latch = '0;
        m_clock = '0;
        m_last_rx = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_confirm_threshold();
        test_time_base();
        test_backpressure();
        test_random_phases();

        wait_results_done();
        // two-stage pipeline: keep clocking to catch any stray beat
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
